/* rtl/aabbpp_pkg.sv */
// ----------------------------------------------------------------------------
// aabbpp_pkg: shared types and helpers for the box push-out block
// Payload types of both channels, the stored box entry, sequencer states,
// register indexes and the fixed point clamp and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package aabbpp_pkg;

	// A coordinate in signed fixed point.
	typedef logic signed [15:0] coord_t;

	// A full box size along one axis.
	typedef logic [14:0] size_t;

	// Wide bound or distance: center plus or minus a grown half-size.
	typedef logic signed [17:0] wide_t;

	// One input beat.
	typedef struct packed {
		logic        mode;
		logic [5:0]  box_index;
		coord_t      box_center_x;
		coord_t      box_center_y;
		coord_t      box_center_z;
		size_t       box_width;
		size_t       box_height;
		size_t       box_length;
		coord_t      point_x;
		coord_t      point_y;
		coord_t      point_z;
	} req_item_t;

	// One result beat.
	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   was_pushed;
		logic   was_clamped;
	} rsp_item_t;

	// One entry of the box table.
	typedef struct packed {
		coord_t cx;
		coord_t cy;
		coord_t cz;
		size_t  sx;
		size_t  sy;
		size_t  sz;
	} box_t;

	// Item kinds carried in the mode field.
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_RESOLVE = 1'b1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_BOX_COUNT    = 3'd0,
		REG_PROBE_RADIUS = 3'd1,
		REG_ROOM_MIN_XZ  = 3'd2,
		REG_ROOM_MAX_XZ  = 3'd3,
		REG_ROOM_MIN_Y   = 3'd4,
		REG_ROOM_MAX_Y   = 3'd5
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLAMP = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// Saturate a wide value to the coordinate range.
	function automatic coord_t sat16(input wide_t v);
		coord_t r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Clamp into [lo, hi]; an inverted range yields lo.
	function automatic coord_t clamp(input coord_t v, input coord_t lo, input coord_t hi);
		coord_t t;
		t = (v < hi) ? v : hi;
		t = (t > lo) ? t : lo;
		return t;
	endfunction

endpackage

`default_nettype wire

/* rtl/aabbpp_if.sv */
// ----------------------------------------------------------------------------
// aabbpp_if: valid/ready channels of the box push-out block
// One interface for the request channel and one for the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabbpp_req_if ();
	logic                  valid;
	logic                  ready;
	aabbpp_pkg::req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aabbpp_rsp_if ();
	logic                  valid;
	logic                  ready;
	aabbpp_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/aabbpp_box_mem.sv */
// ----------------------------------------------------------------------------
// aabbpp_box_mem: box table storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aabbpp_box_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire aabbpp_pkg::box_t wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output aabbpp_pkg::box_t      rdata
);

	aabbpp_pkg::box_t mem_q [DEPTH];
	aabbpp_pkg::box_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/aabbpp_box_unit.sv */
// ----------------------------------------------------------------------------
// aabbpp_box_unit: shared box test and push-out unit
// Registers the grown bounds of the box read from the table, then tests the
// working point against them and moves it onto the face of least penetration.
// ----------------------------------------------------------------------------
`default_nettype none

module aabbpp_box_unit (
	input  wire logic               clk,
	input  wire aabbpp_pkg::box_t   box,
	input  wire aabbpp_pkg::size_t  radius,
	input  wire aabbpp_pkg::coord_t p [3],
	output aabbpp_pkg::coord_t      p_next [3],
	output logic                    moved
);

	aabbpp_pkg::coord_t c [3];
	aabbpp_pkg::size_t  s [3];
	logic [16:0]        h [3];
	aabbpp_pkg::wide_t  lo_s2 [3];
	aabbpp_pkg::wide_t  hi_s2 [3];
	aabbpp_pkg::wide_t  d [6];
	logic               in_box;
	logic [2:0]         i01, i23, i45, i03, best;
	logic [1:0]         ax;
	aabbpp_pkg::coord_t face;

	assign c[0] = box.cx;
	assign c[1] = box.cy;
	assign c[2] = box.cz;
	assign s[0] = box.sx;
	assign s[1] = box.sy;
	assign s[2] = box.sz;

	// Half-size grown by the probe radius.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			h[a] = 17'(s[a][14:1]) + 17'(radius);
		end
	end

	// Wide bounds of the grown box, independent of the point.
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			lo_s2[a] <= {{2{c[a][15]}}, c[a]} - {1'b0, h[a]};
			hi_s2[a] <= {{2{c[a][15]}}, c[a]} + {1'b0, h[a]};
		end
	end

	// Distances to the six faces; all non-negative means inside.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			d[2*a]   = {{2{p[a][15]}}, p[a]} - lo_s2[a];
			d[2*a+1] = hi_s2[a] - {{2{p[a][15]}}, p[a]};
		end
		in_box = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (d[k][17]) begin
				in_box = 1'b0;
			end
		end
	end

	// Smallest distance; the lower face index wins a tie.
	always_comb begin
		i01  = (d[1] < d[0]) ? 3'd1 : 3'd0;
		i23  = (d[3] < d[2]) ? 3'd3 : 3'd2;
		i45  = (d[5] < d[4]) ? 3'd5 : 3'd4;
		i03  = (d[i23] < d[i01]) ? i23 : i01;
		best = (d[i45] < d[i03]) ? i45 : i03;
		ax   = best[2:1];
		face = aabbpp_pkg::sat16(best[0] ? hi_s2[ax] : lo_s2[ax]);
	end

	// Move the chosen axis onto its face.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			p_next[a] = (in_box && (ax == 2'(a))) ? face : p[a];
		end
		moved = in_box && (face != p[ax]);
	end

endmodule

`default_nettype wire

/* rtl/aabb_point_push_out.sv */
// ----------------------------------------------------------------------------
// aabb_point_push_out: point against box table, push-out to nearest face
// Top level: configuration registers, sequencer, room clamp and result
// register around the box table and the shared box test unit.
// ----------------------------------------------------------------------------
// A load beat (mode 0) writes one box table entry in the cycle it is accepted
// and gives no result. A resolve beat (mode 1) clamps the point into the room,
// then walks boxes 0 to box_count-1 (limited to NUM_BOXES) through a single
// box test unit fed by the table's read port, one box per cycle, and returns
// one result beat. A resolve occupies the block through its clamp, walk and
// done states, with one table read per box and the two-stage read and bounds
// pipeline in front of the test unit. Loads are accepted back to back.
// The result sits in an output register, so loads are still
// accepted while a result waits to be taken. Table entries must be written
// before a resolve reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_point_push_out #(
	parameter int NUM_BOXES = 64,
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	aabbpp_req_if.sink       req,
	aabbpp_rsp_if.source     rsp
);

	localparam int AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
	localparam int CW = $clog2(NUM_BOXES + 1);

	// Reset values, rounded to nearest; the room x/z bounds and the y maximum are saturated.
	localparam int Scale     = 1 << FRAC_BITS;
	localparam int RadRaw    = (4 * Scale + 5) / 10;
	localparam int XzRaw     = (206 * Scale + 5) / 10;
	localparam int MaxYRaw   = (246 * Scale + 5) / 10;
	localparam logic [14:0] RstRadius = 15'(RadRaw);
	localparam logic signed [15:0] RstMaxXz =
		(XzRaw > 32767) ? 16'sh7fff : 16'(XzRaw);
	localparam logic signed [15:0] RstMinXz =
		(XzRaw >= 32768) ? 16'sh8000 : 16'(-XzRaw);
	localparam logic signed [15:0] RstMinY = 16'(RadRaw);
	localparam logic signed [15:0] RstMaxY =
		(MaxYRaw > 32767) ? 16'sh7fff : 16'(MaxYRaw);

	aabbpp_pkg::state_t    state_q;
	logic [6:0]            box_count_q;
	aabbpp_pkg::size_t     probe_radius_q;
	aabbpp_pkg::coord_t    room_min_xz_q, room_max_xz_q, room_min_y_q, room_max_y_q;
	aabbpp_pkg::coord_t    pt_q [3];
	aabbpp_pkg::coord_t    p_q [3];
	aabbpp_pkg::coord_t    p_next [3];
	logic                  pushed_q, clamped_q, moved;
	logic [CW-1:0]         rd_cnt_q, walk_len;
	logic                  rd_v_s1, bnd_v_s2;
	logic                  issue, req_fire, load_we;
	aabbpp_pkg::box_t      load_box, rd_box;
	aabbpp_pkg::rsp_item_t rsp_q;
	logic                  rsp_valid_q;
	aabbpp_pkg::coord_t    cl_x, cl_y, cl_z;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q    <= '0;
			probe_radius_q <= RstRadius;
			room_min_xz_q  <= RstMinXz;
			room_max_xz_q  <= RstMaxXz;
			room_min_y_q   <= RstMinY;
			room_max_y_q   <= RstMaxY;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				aabbpp_pkg::REG_BOX_COUNT:    box_count_q    <= cfg_data[6:0];
				aabbpp_pkg::REG_PROBE_RADIUS: probe_radius_q <= cfg_data[14:0];
				aabbpp_pkg::REG_ROOM_MIN_XZ:  room_min_xz_q  <= cfg_data;
				aabbpp_pkg::REG_ROOM_MAX_XZ:  room_max_xz_q  <= cfg_data;
				aabbpp_pkg::REG_ROOM_MIN_Y:   room_min_y_q   <= cfg_data;
				aabbpp_pkg::REG_ROOM_MAX_Y:   room_max_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request handshake and table writes.
	assign req.ready = (state_q == aabbpp_pkg::ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign load_we   = req_fire && (req.data.mode == aabbpp_pkg::MODE_LOAD) &&
		(32'(req.data.box_index) < NUM_BOXES);

	assign load_box.cx = req.data.box_center_x;
	assign load_box.cy = req.data.box_center_y;
	assign load_box.cz = req.data.box_center_z;
	assign load_box.sx = req.data.box_width;
	assign load_box.sy = req.data.box_height;
	assign load_box.sz = req.data.box_length;

	// Number of boxes walked, limited to the table size.
	assign walk_len = (32'(box_count_q) < NUM_BOXES) ? CW'(box_count_q) : CW'(NUM_BOXES);
	assign issue    = (state_q == aabbpp_pkg::ST_WALK) && (rd_cnt_q < walk_len);

	aabbpp_box_mem #(
		.DEPTH (NUM_BOXES),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(req.data.box_index)),
		.wdata (load_box),
		.re    (issue),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rd_box)
	);

	aabbpp_box_unit u_unit (
		.clk    (clk),
		.box    (rd_box),
		.radius (probe_radius_q),
		.p      (p_q),
		.p_next (p_next),
		.moved  (moved)
	);

	// Room clamp of the captured point.
	assign cl_x = aabbpp_pkg::clamp(pt_q[0], room_min_xz_q, room_max_xz_q);
	assign cl_y = aabbpp_pkg::clamp(pt_q[1], room_min_y_q, room_max_y_q);
	assign cl_z = aabbpp_pkg::clamp(pt_q[2], room_min_xz_q, room_max_xz_q);

	// Sequencer, read counter and pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aabbpp_pkg::ST_IDLE;
			rd_cnt_q    <= '0;
			rd_v_s1     <= 1'b0;
			bnd_v_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= issue;
			bnd_v_s2 <= rd_v_s1;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			// The done state reloads the result register itself.
			if (rsp_valid_q && rsp.ready && (state_q != aabbpp_pkg::ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				aabbpp_pkg::ST_IDLE: begin
					if (req_fire && (req.data.mode == aabbpp_pkg::MODE_RESOLVE)) begin
						state_q <= aabbpp_pkg::ST_CLAMP;
					end
				end
				aabbpp_pkg::ST_CLAMP: begin
					rd_cnt_q <= '0;
					state_q  <= aabbpp_pkg::ST_WALK;
				end
				aabbpp_pkg::ST_WALK: begin
					if (!issue && !rd_v_s1 && !bnd_v_s2) begin
						state_q <= aabbpp_pkg::ST_DONE;
					end
				end
				aabbpp_pkg::ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= aabbpp_pkg::ST_IDLE;
					end
				end
				default: state_q <= aabbpp_pkg::ST_IDLE;
			endcase
		end
	end

	// Working point and flags.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			pt_q[0] <= req.data.point_x;
			pt_q[1] <= req.data.point_y;
			pt_q[2] <= req.data.point_z;
		end
		if (state_q == aabbpp_pkg::ST_CLAMP) begin
			p_q[0]    <= cl_x;
			p_q[1]    <= cl_y;
			p_q[2]    <= cl_z;
			clamped_q <= (cl_x != pt_q[0]) || (cl_y != pt_q[1]) || (cl_z != pt_q[2]);
			pushed_q  <= 1'b0;
		end else if (bnd_v_s2) begin
			p_q <= p_next;
			if (moved) begin
				pushed_q <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if ((state_q == aabbpp_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready)) begin
			rsp_q.out_x       <= p_q[0];
			rsp_q.out_y       <= p_q[1];
			rsp_q.out_z       <= p_q[2];
			rsp_q.was_pushed  <= pushed_q;
			rsp_q.was_clamped <= clamped_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the box push-out block
// Feeds load and resolve beats through the request channel with random gaps,
// stalls the result channel at random and once for a long stretch, and checks
// every result beat in order against a behavioural prediction built from its
// own copy of the box table and of the configuration registers.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import aabbpp_pkg::*;

	localparam int TABLE_DEPTH   = 64;
	localparam int ITEM_TARGET   = 1900;
	localparam int DRAIN_LIMIT   = 60000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 500;

	// Register indexes past the end of the register list.
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [15:0] cfg_data;

	aabbpp_req_if req ();
	aabbpp_rsp_if rsp ();

	aabb_point_push_out u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	// Shadow of the box table and of the registers.
	box_t box_tab [TABLE_DEPTH];
	int   cfg_count  = 0;
	int   cfg_radius = 102;
	int   cfg_min_xz = -5274;
	int   cfg_max_xz = 5274;
	int   cfg_min_y  = 102;
	int   cfg_max_y  = 6298;

	rsp_item_t expected_points [$];
	req_item_t pend_q [$];
	int        err_count    = 0;
	int        result_count = 0;

	// Handshake bookkeeping shared by the drivers and the monitors.
	bit req_busy;
	bit req_taken;
	bit rsp_taken;
	bit tx_calm;
	bit rx_calm;
	bit rx_hold;
	bit hold_req;
	int req_wait = -1;
	int rsp_wait = 0;

	task automatic flag_error(input string msg);
		err_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic int clip16(input int v);
		int r;
		r = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
		return r;
	endfunction

	function automatic int limit_coord(input int v, input int lo, input int hi,
			inout bit changed);
		int t;
		t = (v < hi) ? v : hi;
		t = (t > lo) ? t : lo;
		if (t != v) begin
			changed = 1'b1;
		end
		return t;
	endfunction

	// Clamp into the room, then push out of every enabled box in index order.
	function automatic rsp_item_t resolve_point(input req_item_t it);
		rsp_item_t r;
		int  p [3];
		int  lo [3];
		int  hi [3];
		int  d [6];
		int  cc [3];
		int  ss [3];
		int  n, best, ax, np, h;
		bit  in_box, pushed, clamped;
		pushed = 1'b0;
		clamped = 1'b0;
		p[0] = limit_coord(it.point_x, cfg_min_xz, cfg_max_xz, clamped);
		p[1] = limit_coord(it.point_y, cfg_min_y, cfg_max_y, clamped);
		p[2] = limit_coord(it.point_z, cfg_min_xz, cfg_max_xz, clamped);
		n = (cfg_count < TABLE_DEPTH) ? cfg_count : TABLE_DEPTH;
		for (int i = 0; i < n; i++) begin
			cc = '{int'(box_tab[i].cx), int'(box_tab[i].cy), int'(box_tab[i].cz)};
			ss = '{int'(box_tab[i].sx), int'(box_tab[i].sy), int'(box_tab[i].sz)};
			in_box = 1'b1;
			for (int a = 0; a < 3; a++) begin
				h = (ss[a] >>> 1) + cfg_radius;
				lo[a] = cc[a] - h;
				hi[a] = cc[a] + h;
				if (p[a] < lo[a] || p[a] > hi[a]) begin
					in_box = 1'b0;
				end
				d[2 * a] = p[a] - lo[a];
				d[2 * a + 1] = hi[a] - p[a];
			end
			if (in_box) begin
				// Least penetration wins; the lower face index wins a tie.
				best = 0;
				for (int k = 1; k < 6; k++) begin
					if (d[k] < d[best]) begin
						best = k;
					end
				end
				ax = best / 2;
				np = clip16((best % 2 == 1) ? hi[ax] : lo[ax]);
				if (np != p[ax]) begin
					pushed = 1'b1;
				end
				p[ax] = np;
			end
		end
		r.out_x = p[0][15:0];
		r.out_y = p[1][15:0];
		r.out_z = p[2][15:0];
		r.was_pushed = pushed;
		r.was_clamped = clamped;
		return r;
	endfunction

	// Item builders: unused fields always carry random bits.
	function automatic req_item_t rand_item();
		req_item_t it;
		it.mode         = 1'($urandom);
		it.box_index    = 6'($urandom);
		it.box_center_x = coord_t'($urandom);
		it.box_center_y = coord_t'($urandom);
		it.box_center_z = coord_t'($urandom);
		it.box_width    = size_t'($urandom);
		it.box_height   = size_t'($urandom);
		it.box_length   = size_t'($urandom);
		it.point_x      = coord_t'($urandom);
		it.point_y      = coord_t'($urandom);
		it.point_z      = coord_t'($urandom);
		return it;
	endfunction

	function automatic req_item_t load_item(input int idx, input int cx, input int cy,
			input int cz, input int w, input int h, input int l);
		req_item_t it;
		it = rand_item();
		it.mode         = MODE_LOAD;
		it.box_index    = 6'(idx);
		it.box_center_x = coord_t'(cx);
		it.box_center_y = coord_t'(cy);
		it.box_center_z = coord_t'(cz);
		it.box_width    = size_t'(w);
		it.box_height   = size_t'(h);
		it.box_length   = size_t'(l);
		return it;
	endfunction

	function automatic req_item_t point_item(input int x, input int y, input int z);
		req_item_t it;
		it = rand_item();
		it.mode    = MODE_RESOLVE;
		it.point_x = coord_t'(x);
		it.point_y = coord_t'(y);
		it.point_z = coord_t'(z);
		return it;
	endfunction

	// A box of room scale: x and z centers within 24 units, y center from -4 to 28 units, sizes up to 16 units.
	function automatic req_item_t room_box(input int idx);
		return load_item(idx,
			int'($urandom_range(0, 12288)) - 6144,
			int'($urandom_range(0, 8192)) - 1024,
			int'($urandom_range(0, 12288)) - 6144,
			$urandom_range(0, 4096), $urandom_range(0, 4096), $urandom_range(0, 4096));
	endfunction

	// A point near box k, or lying exactly on one of its grown faces.
	function automatic req_item_t aimed_point(input int k, input bit on_face);
		int cc [3];
		int ss [3];
		int v [3];
		int h, span, face_ax;
		cc = '{int'(box_tab[k].cx), int'(box_tab[k].cy), int'(box_tab[k].cz)};
		ss = '{int'(box_tab[k].sx), int'(box_tab[k].sy), int'(box_tab[k].sz)};
		face_ax = $urandom_range(0, 2);
		for (int a = 0; a < 3; a++) begin
			h = (ss[a] >>> 1) + cfg_radius;
			if (on_face && a == face_ax) begin
				v[a] = ($urandom_range(0, 1) == 1) ? cc[a] + h : cc[a] - h;
			end else begin
				span = (h + 32 > 30000) ? 30000 : h + 32;
				v[a] = cc[a] - span + int'($urandom_range(0, 2 * span));
			end
		end
		return point_item(clip16(v[0]), clip16(v[1]), clip16(v[2]));
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
		case (idx)
			REG_BOX_COUNT: begin
				cfg_count = val[6:0];
			end
			REG_PROBE_RADIUS: begin
				cfg_radius = val[14:0];
			end
			REG_ROOM_MIN_XZ: begin
				cfg_min_xz = coord_t'(val);
			end
			REG_ROOM_MAX_XZ: begin
				cfg_max_xz = coord_t'(val);
			end
			REG_ROOM_MIN_Y: begin
				cfg_min_y = coord_t'(val);
			end
			REG_ROOM_MAX_Y: begin
				cfg_max_y = coord_t'(val);
			end
			default: begin
			end
		endcase
	endtask

	// Wait until every queued beat is sent and every result has come back.
	task automatic wait_idle();
		int n;
		n = 0;
		while ((pend_q.size() != 0 || req_busy || expected_points.size() != 0)
				&& n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_points.size() != 0) begin
			flag_error($sformatf("%0d expected results never arrived",
				expected_points.size()));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Request driver: one gap drawn per beat, valid held until the beat is taken.
	always @(negedge clk) begin : drive_req
		logic      nv;
		req_item_t nd;
		nv = req.valid;
		nd = req.data;
		if (arst_n) begin
			if (req_taken) begin
				req_taken = 1'b0;
				req_busy = 1'b0;
				nv = 1'b0;
			end
			if (!req_busy && pend_q.size() != 0) begin
				if (req_wait < 0) begin
					req_wait = tx_calm ? 0 : $urandom_range(0, 6);
				end
				if (req_wait == 0) begin
					nd = pend_q.pop_front();
					nv = 1'b1;
					req_busy = 1'b1;
					req_wait = -1;
				end else begin
					req_wait--;
				end
			end
		end
		req.valid <= nv;
		req.data <= nd;
	end

	// Request monitor: loads update the shadow table, resolves are predicted.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			if (req.data.mode == MODE_LOAD) begin
				box_tab[req.data.box_index].cx = req.data.box_center_x;
				box_tab[req.data.box_index].cy = req.data.box_center_y;
				box_tab[req.data.box_index].cz = req.data.box_center_z;
				box_tab[req.data.box_index].sx = req.data.box_width;
				box_tab[req.data.box_index].sy = req.data.box_height;
				box_tab[req.data.box_index].sz = req.data.box_length;
			end else begin
				expected_points.push_back(resolve_point(req.data));
			end
			req_taken = 1'b1;
		end
	end

	// Result ready driver: a stall drawn per beat, plus the long hold-off.
	always @(negedge clk) begin : drive_rsp
		logic nr;
		if (rsp_taken) begin
			rsp_taken = 1'b0;
			rsp_wait = rx_calm ? 0 : $urandom_range(0, 6);
		end
		if (!arst_n || rx_hold) begin
			nr = 1'b0;
		end else if (rsp_wait > 0) begin
			nr = 1'b0;
			rsp_wait--;
		end else begin
			nr = 1'b1;
		end
		rsp.ready <= nr;
	end

	// Long hold-off on the result side so that the block backs up its input.
	initial begin : rx_hold_off
		rx_hold = 1'b0;
		wait (hold_req);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Result monitor: every beat is compared with the oldest prediction.
	always @(posedge clk) begin : check_rsp
		rsp_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			rsp_taken = 1'b1;
			result_count++;
			if (expected_points.size() == 0) begin
				flag_error($sformatf("result %0d arrived with nothing expected",
					result_count));
			end else begin
				want = expected_points.pop_front();
				if (rsp.data.out_x !== want.out_x) begin
					flag_error($sformatf("result %0d out_x %0d, expected %0d",
						result_count, rsp.data.out_x, want.out_x));
				end
				if (rsp.data.out_y !== want.out_y) begin
					flag_error($sformatf("result %0d out_y %0d, expected %0d",
						result_count, rsp.data.out_y, want.out_y));
				end
				if (rsp.data.out_z !== want.out_z) begin
					flag_error($sformatf("result %0d out_z %0d, expected %0d",
						result_count, rsp.data.out_z, want.out_z));
				end
				if (rsp.data.was_pushed !== want.was_pushed) begin
					flag_error($sformatf("result %0d was_pushed %b, expected %b",
						result_count, rsp.data.was_pushed, want.was_pushed));
				end
				if (rsp.data.was_clamped !== want.was_clamped) begin
					flag_error($sformatf("result %0d was_clamped %b, expected %b",
						result_count, rsp.data.was_clamped, want.was_clamped));
				end
			end
		end
	end

	initial begin : stimulus
		int phase, items, nitems, cnt, rv, neff, r, idx;
		int lo, hi, ylo, yhi;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_data  = '0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, no boxes: only the room clamp acts.
		pend_q.push_back(point_item(32767, -32768, 32767));
		pend_q.push_back(point_item(0, 1000, -1000));
		pend_q.push_back(point_item(-32768, 32767, -32768));
		wait_idle();

		// Open room, no radius, four boxes, two of them at the extremes of the fields.
		write_reg(REG_BOX_COUNT, 16'd4);
		write_reg(REG_PROBE_RADIUS, 16'd0);
		write_reg(REG_ROOM_MIN_XZ, 16'h8000);
		write_reg(REG_ROOM_MAX_XZ, 16'h7fff);
		write_reg(REG_ROOM_MIN_Y, 16'h8000);
		write_reg(REG_ROOM_MAX_Y, 16'h7fff);
		@(posedge clk);
		pend_q.push_back(load_item(0, 0, 0, 0, 512, 512, 512));
		pend_q.push_back(load_item(1, 32767, 32767, 32767, 32767, 32767, 32767));
		pend_q.push_back(load_item(2, -32768, -32768, -32768, 32767, 32767, 32767));
		pend_q.push_back(load_item(3, 2000, 2000, 2000, 0, 0, 0));
		// Centre of a cube: every face ties and the lowest face wins.
		pend_q.push_back(point_item(0, 0, 0));
		// Exactly on a face: inside, but the point does not move; then a point just inside that is pushed.
		pend_q.push_back(point_item(256, 0, 100));
		pend_q.push_back(point_item(200, -50, 250));
		// Faces beyond the coordinate range: a push onto such a face saturates.
		pend_q.push_back(point_item(32767, 32767, 32767));
		pend_q.push_back(point_item(-32768, -32768, -32768));
		pend_q.push_back(point_item(32000, 20000, 32767));
		// A box of zero size still holds a point lying on its centre.
		pend_q.push_back(point_item(2000, 2000, 2000));
		wait_idle();

		// Largest radius and an inverted room on both axis groups.
		write_reg(REG_PROBE_RADIUS, 16'h7fff);
		write_reg(REG_ROOM_MIN_XZ, 16'd256);
		write_reg(REG_ROOM_MAX_XZ, -16'sd256);
		write_reg(REG_ROOM_MIN_Y, 16'd1000);
		write_reg(REG_ROOM_MAX_Y, -16'sd1000);
		@(posedge clk);
		pend_q.push_back(point_item(0, 0, 0));
		pend_q.push_back(point_item(-32768, 32767, 12345));
		pend_q.push_back(room_box(0));
		pend_q.push_back(rand_item());
		pend_q.push_back(point_item(int'($urandom_range(0, 65535)) - 32768, 0, 0));
		wait_idle();

		// Random phases, each with its own register settings.
		phase = 0;
		items = 0;
		while (items < ITEM_TARGET) begin
			if (phase == 3 || phase == 13) begin
				cnt = 64;
			end else if (phase == 7) begin
				cnt = 127;
			end else if (phase == 11) begin
				cnt = 100;
			end else if (phase % 6 == 5) begin
				cnt = 0;
			end else begin
				cnt = $urandom_range(1, 8);
			end
			case (phase % 4)
				0: rv = 0;
				1: rv = 32767;
				2: rv = $urandom_range(0, 512);
				default: rv = $urandom_range(0, 32767);
			endcase
			case (phase % 5)
				0: begin
					lo = -5274; hi = 5274; ylo = 102; yhi = 6298;
				end
				1: begin
					lo = -32768; hi = 32767; ylo = -32768; yhi = 32767;
				end
				2: begin
					lo = $urandom_range(0, 4000);
					hi = lo - 1 - int'($urandom_range(0, 4000));
					ylo = $urandom_range(0, 4000);
					yhi = ylo - 1 - int'($urandom_range(0, 4000));
				end
				3: begin
					lo = -int'($urandom_range(0, 2000));
					hi = $urandom_range(0, 2000);
					ylo = -int'($urandom_range(0, 2000));
					yhi = $urandom_range(0, 2000);
				end
				default: begin
					lo = coord_t'($urandom); hi = coord_t'($urandom);
					ylo = coord_t'($urandom); yhi = coord_t'($urandom);
				end
			endcase
			// Upper data bits beyond a register's width are junk on purpose.
			write_reg(REG_BOX_COUNT, {9'($urandom), 7'(cnt)});
			write_reg(REG_PROBE_RADIUS, {1'($urandom), 15'(rv)});
			write_reg(REG_ROOM_MIN_XZ, 16'(lo));
			write_reg(REG_ROOM_MAX_XZ, 16'(hi));
			write_reg(REG_ROOM_MIN_Y, 16'(ylo));
			write_reg(REG_ROOM_MAX_Y, 16'(yhi));
			write_reg((phase % 2 == 1) ? REG_SPARE_7 : REG_SPARE_6, 16'($urandom));
			tx_calm = (phase % 3 == 2);
			rx_calm = (phase % 4 == 2);
			@(posedge clk);

			// Fill the whole table first so that no resolve reads a blank entry.
			if (phase == 0) begin
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					pend_q.push_back(room_box(k));
				end
				items += TABLE_DEPTH;
			end
			if (phase == 2) begin
				hold_req = 1'b1;
			end

			neff = (cfg_count < TABLE_DEPTH) ? cfg_count : TABLE_DEPTH;
			nitems = (neff > 16) ? 40 : $urandom_range(80, 130);
			for (int k = 0; k < nitems; k++) begin
				r = $urandom_range(0, 99);
				if (r < 25) begin
					if (neff > 0 && $urandom_range(0, 1) == 1) begin
						idx = $urandom_range(0, neff - 1);
					end else begin
						idx = $urandom_range(0, TABLE_DEPTH - 1);
					end
					if ($urandom_range(0, 9) < 7) begin
						pend_q.push_back(room_box(idx));
					end else begin
						pend_q.push_back(load_item(idx, coord_t'($urandom),
							coord_t'($urandom), coord_t'($urandom), $urandom_range(0, 32767),
							$urandom_range(0, 32767), $urandom_range(0, 32767)));
					end
				end else if (r < 85 && neff > 0) begin
					pend_q.push_back(aimed_point($urandom_range(0, neff - 1), r >= 72));
				end else begin
					pend_q.push_back(rand_item());
				end
			end
			items += nitems;
			wait_idle();
			phase++;
		end

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* aabb_point_push_out.f */
rtl/aabbpp_pkg.sv
rtl/aabbpp_if.sv
rtl/aabbpp_box_mem.sv
rtl/aabbpp_box_unit.sv
rtl/aabb_point_push_out.sv
tb/tb_top.sv
